### design/mfa_pkg.sv
package mfa_pkg;

   // Field widths of the request and response transactions
   localparam int FIELD_BITS = 16;
   localparam int WHOLE_BITS = 35;
   localparam int FRAC_BITS  = 32;

   // Shared datapath: 64-bit values plus one carry bit
   localparam int DP_BITS    = 64;
   localparam int CNT_BITS   = $clog2(DP_BITS + 1);
   localparam int SHIFT_BITS = $clog2(DP_BITS);

   typedef enum logic [1:0] {
      FN_ADD = 2'd0,
      FN_SUB = 2'd1,
      FN_MUL = 2'd2,
      FN_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_MUL_NUM,
      S_MUL_AUX,
      S_MUL_DEN,
      S_COMBINE,
      S_NEGATE,
      S_VALIDATE,
      S_GCD_STRIP,
      S_GCD_RUN,
      S_DIV_NUM,
      S_DIV_DEN,
      S_DIV_WHOLE,
      S_CHECK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [DP_BITS:0] x;
      logic [DP_BITS:0] y;
      logic             sub;
   } alu_in_type;

   typedef struct packed {
      logic [DP_BITS:0] res;
      logic             cout;
   } alu_out_type;

endpackage

### design/mfa_if.sv
interface mfa_req_if import mfa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [FIELD_BITS-1:0] a_whole;
   logic [FIELD_BITS-1:0] a_num;
   logic [FIELD_BITS-1:0] a_den;
   logic [FIELD_BITS-1:0] b_whole;
   logic [FIELD_BITS-1:0] b_num;
   logic [FIELD_BITS-1:0] b_den;

   modport source (output valid, func, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   input ready);
   modport sink (input valid, func, a_whole, a_num, a_den, b_whole, b_num, b_den,
                 output ready);
   modport monitor (input valid, ready, func, a_whole, a_num, a_den, b_whole, b_num,
                    b_den);
endinterface

interface mfa_rsp_if import mfa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic                  negative;
   logic [WHOLE_BITS-1:0] res_whole;
   logic [FRAC_BITS-1:0]  res_num;
   logic [FRAC_BITS-1:0]  res_den;

   modport source (output valid, status, negative, res_whole, res_num, res_den,
                   input ready);
   modport sink (input valid, status, negative, res_whole, res_num, res_den,
                 output ready);
   modport monitor (input valid, ready, status, negative, res_whole, res_num, res_den);
endinterface

### design/mfa_alu.sv
module mfa_alu import mfa_pkg::*; (
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [DP_BITS+1:0] total;

   // Add, or subtract as x + ~y + 1; cout set means no borrow on subtract
   always_comb begin
      total = {1'b0, alu_in.x}
            + {1'b0, alu_in.y ^ {(DP_BITS+1){alu_in.sub}}}
            + {{(DP_BITS+1){1'b0}}, alu_in.sub};
      alu_out.res  = total[DP_BITS:0];
      alu_out.cout = total[DP_BITS+1];
   end

endmodule

### design/mixed_fraction_arith_unit_top.sv
// Mixed fraction arithmetic unit.
// A request transaction on req_ch carries an operation (add, subtract,
// multiply, divide) and two mixed fractions whole + num/den. One response
// transaction on rsp_ch returns a status, a sign and the reduced result as a
// mixed magnitude res_whole + res_num/res_den with res_num below res_den.
// Status: ok, zero operand denominator, divide by a zero value, or result out
// of range; any error returns 0 + 0/1, not negative.
// All adds and subtracts run on one shared 65-bit add/subtract unit under a
// sequencer: shift-add multiplies, the binary GCD and three restoring
// divides. A zero denominator goes from idle straight to the finish state.
// req_ch.ready is high only while the sequencer idles, so one transaction is
// in work at a time.
// The result sits in an output register: the next request is accepted while
// an earlier response waits, and a stalled rsp_ch holds the finished result
// in the sequencer until the register frees up.
// Reset (synchronous, active high) drops any work in progress and any
// pending response and returns to idle.
module mixed_fraction_arith_unit_top import mfa_pkg::*; #(
   parameter int OPERAND_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mfa_req_if.sink    req_ch,
   mfa_rsp_if.source  rsp_ch
);

   // Operand bits that reach the datapath; higher input bits are masked off
   localparam int OpW = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;

   // Sequencer and control
   state_type            state_ff, state_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Captured operands
   func_type             func_ff, func_in;
   logic [OpW-1:0]       aw_ff, aw_in, an_ff, an_in, ad_ff, ad_in;
   logic [OpW-1:0]       bw_ff, bw_in, bn_ff, bn_in, bd_ff, bd_in;

   // Working values
   status_type           stat_ff, stat_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic [DP_BITS-1:0]   a_ff, a_in, b_ff, b_in;
   logic [DP_BITS-1:0]   num_ff, num_in, aux_ff, aux_in, den_ff, den_in;
   logic [DP_BITS-1:0]   whole_ff, whole_in;

   // Multiplier registers
   logic [DP_BITS-1:0]   acc_ff, acc_in, mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic                 big_ff, big_in;

   // GCD and divider registers
   logic [DP_BITS-1:0]   u_ff, u_in, v_ff, v_in;
   logic [SHIFT_BITS-1:0] k_ff, k_in;
   logic [DP_BITS-1:0]   rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // Response register
   logic [1:0]            out_status_ff, out_status_in;
   logic                  out_neg_ff, out_neg_in;
   logic [WHOLE_BITS-1:0] out_whole_ff, out_whole_in;
   logic [FRAC_BITS-1:0]  out_num_ff, out_num_in;
   logic [FRAC_BITS-1:0]  out_den_ff, out_den_in;

   // Decoded control
   logic                 req_ready;
   logic                 accept;
   logic                 in_zero_den;
   logic                 add_sub;
   logic                 mul_done;
   logic                 div_done;
   logic                 div_zero;
   logic                 strip_more;
   logic                 out_load;
   logic [DP_BITS-1:0]   ld_acc, ld_mcand, ld_mplier, ld_dividend;
   alu_in_type           alu_in;
   alu_out_type          alu_out;

   mfa_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // Control decode and shared unit operand selection
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      accept      = req_ready && req_ch.valid;
      in_zero_den = (req_ch.a_den[OpW-1:0] == '0) || (req_ch.b_den[OpW-1:0] == '0);
      add_sub     = (func_ff == FN_ADD) || (func_ff == FN_SUB);
      mul_done    = busy_ff && (mplier_ff == '0);
      div_done    = busy_ff && (cnt_ff == '0);
      // B is still in the accumulator when its multiply finishes
      div_zero    = (func_ff == FN_DIV) && (acc_ff == '0) && !ovf_ff;
      strip_more  = (u_ff != '0) && !u_ff[0] && !v_ff[0];
      out_load    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

      ld_acc      = '0;
      ld_mcand    = '0;
      ld_mplier   = '0;
      ld_dividend = '0;
      case (state_ff)
         S_MUL_A: begin
            ld_acc    = DP_BITS'(an_ff);
            ld_mcand  = DP_BITS'(aw_ff);
            ld_mplier = DP_BITS'(ad_ff);
         end
         S_MUL_B: begin
            ld_acc    = DP_BITS'(bn_ff);
            ld_mcand  = DP_BITS'(bw_ff);
            ld_mplier = DP_BITS'(bd_ff);
         end
         S_MUL_NUM: begin
            ld_mcand  = a_ff;
            ld_mplier = (func_ff == FN_MUL) ? b_ff : DP_BITS'(bd_ff);
         end
         S_MUL_AUX: begin
            ld_mcand  = b_ff;
            ld_mplier = DP_BITS'(ad_ff);
         end
         S_MUL_DEN: begin
            ld_mcand  = DP_BITS'(ad_ff);
            ld_mplier = (func_ff == FN_DIV) ? b_ff : DP_BITS'(bd_ff);
         end
         S_DIV_NUM:   ld_dividend = num_ff;
         S_DIV_DEN:   ld_dividend = den_ff;
         S_DIV_WHOLE: ld_dividend = num_ff;
         default: begin
         end
      endcase

      alu_in.x   = '0;
      alu_in.y   = '0;
      alu_in.sub = 1'b0;
      case (state_ff)
         S_MUL_A, S_MUL_B, S_MUL_NUM, S_MUL_AUX, S_MUL_DEN: begin
            alu_in.x = {1'b0, acc_ff};
            alu_in.y = {1'b0, mcand_ff};
         end
         S_COMBINE: begin
            alu_in.x   = {1'b0, num_ff};
            alu_in.y   = {1'b0, aux_ff};
            alu_in.sub = (func_ff == FN_SUB);
         end
         S_NEGATE: begin
            alu_in.y   = {1'b0, num_ff};
            alu_in.sub = 1'b1;
         end
         S_GCD_RUN: begin
            alu_in.x   = {1'b0, u_ff};
            alu_in.y   = {1'b0, v_ff};
            alu_in.sub = 1'b1;
         end
         S_DIV_NUM, S_DIV_DEN, S_DIV_WHOLE: begin
            alu_in.x   = {rem_ff, quo_ff[DP_BITS-1]};
            alu_in.y   = {1'b0, dvs_ff};
            alu_in.sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = in_zero_den ? S_FINISH : S_MUL_A;
            end
         end
         S_MUL_A: begin
            if (mul_done) begin
               state_in = S_MUL_B;
            end
         end
         S_MUL_B: begin
            if (mul_done) begin
               state_in = div_zero ? S_FINISH : S_MUL_NUM;
            end
         end
         S_MUL_NUM: begin
            if (mul_done) begin
               state_in = add_sub ? S_MUL_AUX : S_MUL_DEN;
            end
         end
         S_MUL_AUX: begin
            if (mul_done) begin
               state_in = S_MUL_DEN;
            end
         end
         S_MUL_DEN: begin
            if (mul_done) begin
               state_in = add_sub ? S_COMBINE : S_VALIDATE;
            end
         end
         S_COMBINE: begin
            state_in = ((func_ff == FN_SUB) && !alu_out.cout) ? S_NEGATE : S_VALIDATE;
         end
         S_NEGATE: state_in = S_VALIDATE;
         S_VALIDATE: begin
            state_in = (ovf_ff || (den_ff == '0)) ? S_FINISH : S_GCD_STRIP;
         end
         S_GCD_STRIP: begin
            if (!strip_more) begin
               state_in = S_GCD_RUN;
            end
         end
         S_GCD_RUN: begin
            if (u_ff == '0) begin
               state_in = S_DIV_NUM;
            end
         end
         S_DIV_NUM: begin
            if (div_done) begin
               state_in = S_DIV_DEN;
            end
         end
         S_DIV_DEN: begin
            if (div_done) begin
               state_in = S_DIV_WHOLE;
            end
         end
         S_DIV_WHOLE: begin
            if (div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = S_FINISH;
         S_FINISH: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      busy_in       = busy_ff;
      func_in       = func_ff;
      aw_in         = aw_ff;
      an_in         = an_ff;
      ad_in         = ad_ff;
      bw_in         = bw_ff;
      bn_in         = bn_ff;
      bd_in         = bd_ff;
      stat_in       = stat_ff;
      ovf_in        = ovf_ff;
      neg_in        = neg_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      num_in        = num_ff;
      aux_in        = aux_ff;
      den_in        = den_ff;
      whole_in      = whole_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      big_in        = big_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      out_status_in = out_status_ff;
      out_neg_in    = out_neg_ff;
      out_whole_in  = out_whole_ff;
      out_num_in    = out_num_ff;
      out_den_in    = out_den_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = func_type'(req_ch.func);
               aw_in   = req_ch.a_whole[OpW-1:0];
               an_in   = req_ch.a_num[OpW-1:0];
               ad_in   = req_ch.a_den[OpW-1:0];
               bw_in   = req_ch.b_whole[OpW-1:0];
               bn_in   = req_ch.b_num[OpW-1:0];
               bd_in   = req_ch.b_den[OpW-1:0];
               stat_in = in_zero_den ? ST_ZERO_DEN : ST_OK;
               ovf_in  = 1'b0;
               neg_in  = 1'b0;
               busy_in = 1'b0;
            end
         end
         S_MUL_A, S_MUL_B, S_MUL_NUM, S_MUL_AUX, S_MUL_DEN: begin
            if (!busy_ff) begin
               acc_in    = ld_acc;
               mcand_in  = ld_mcand;
               mplier_in = ld_mplier;
               big_in    = 1'b0;
               busy_in   = 1'b1;
            end else if (mul_done) begin
               busy_in = 1'b0;
               case (state_ff)
                  S_MUL_A:   a_in = acc_ff;
                  S_MUL_B: begin
                     b_in = acc_ff;
                     if (div_zero) begin
                        stat_in = ST_DIV_ZERO;
                     end
                  end
                  S_MUL_NUM: num_in = acc_ff;
                  S_MUL_AUX: aux_in = acc_ff;
                  default:   den_in = acc_ff;
               endcase
            end else begin
               // One shift-add step; flag any partial sum past 64 bits
               if (mplier_ff[0]) begin
                  acc_in = alu_out.res[DP_BITS-1:0];
                  if (alu_out.res[DP_BITS] || big_ff) begin
                     ovf_in = 1'b1;
                  end
               end
               big_in    = big_ff | mcand_ff[DP_BITS-1];
               mcand_in  = {mcand_ff[DP_BITS-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[DP_BITS-1:1]};
            end
         end
         S_COMBINE: begin
            num_in = alu_out.res[DP_BITS-1:0];
            if (func_ff == FN_ADD) begin
               ovf_in = ovf_ff | alu_out.res[DP_BITS];
            end else if (!alu_out.cout) begin
               neg_in = 1'b1;
            end
         end
         S_NEGATE: num_in = alu_out.res[DP_BITS-1:0];
         S_VALIDATE: begin
            if (ovf_ff || (den_ff == '0)) begin
               stat_in = ST_RANGE;
            end
            u_in = num_ff;
            v_in = den_ff;
            k_in = '0;
         end
         S_GCD_STRIP: begin
            // Pull out the common power of two
            if (strip_more) begin
               u_in = {1'b0, u_ff[DP_BITS-1:1]};
               v_in = {1'b0, v_ff[DP_BITS-1:1]};
               k_in = k_ff + 1'b1;
            end
         end
         S_GCD_RUN: begin
            if (u_ff == '0) begin
               dvs_in  = v_ff << k_ff;
               busy_in = 1'b0;
            end else if (!u_ff[0]) begin
               u_in = {1'b0, u_ff[DP_BITS-1:1]};
            end else if (!v_ff[0]) begin
               v_in = {1'b0, v_ff[DP_BITS-1:1]};
            end else if (alu_out.cout) begin
               u_in = {1'b0, alu_out.res[DP_BITS-1:1]};
            end else begin
               // Swap so that the next subtract does not borrow
               u_in = v_ff;
               v_in = u_ff;
            end
         end
         S_DIV_NUM, S_DIV_DEN, S_DIV_WHOLE: begin
            if (!busy_ff) begin
               rem_in  = '0;
               quo_in  = ld_dividend;
               cnt_in  = CNT_BITS'(DP_BITS);
               busy_in = 1'b1;
               if (state_ff == S_DIV_WHOLE) begin
                  dvs_in = den_ff;
               end
            end else if (div_done) begin
               busy_in = 1'b0;
               case (state_ff)
                  S_DIV_NUM: num_in = quo_ff;
                  S_DIV_DEN: den_in = quo_ff;
                  default: begin
                     whole_in = quo_ff;
                     num_in   = rem_ff;
                  end
               endcase
            end else begin
               // One restoring divide step
               if (alu_out.cout) begin
                  rem_in = alu_out.res[DP_BITS-1:0];
               end else begin
                  rem_in = {rem_ff[DP_BITS-2:0], quo_ff[DP_BITS-1]};
               end
               quo_in = {quo_ff[DP_BITS-2:0], alu_out.cout};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_CHECK: begin
            if ((den_ff[DP_BITS-1:FRAC_BITS] != '0) ||
                (whole_ff[DP_BITS-1:WHOLE_BITS] != '0)) begin
               stat_in = ST_RANGE;
            end
            if ((whole_ff == '0) && (num_ff == '0)) begin
               neg_in = 1'b0;
            end
         end
         S_FINISH: begin
            if (out_load) begin
               out_status_in = stat_ff;
               if (stat_ff == ST_OK) begin
                  out_neg_in   = neg_ff;
                  out_whole_in = whole_ff[WHOLE_BITS-1:0];
                  out_num_in   = num_ff[FRAC_BITS-1:0];
                  out_den_in   = den_ff[FRAC_BITS-1:0];
               end else begin
                  out_neg_in   = 1'b0;
                  out_whole_in = '0;
                  out_num_in   = '0;
                  out_den_in   = FRAC_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase

      // Hold the response until taken; a new one replaces it in the same cycle
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      aw_ff         <= aw_in;
      an_ff         <= an_in;
      ad_ff         <= ad_in;
      bw_ff         <= bw_in;
      bn_ff         <= bn_in;
      bd_ff         <= bd_in;
      stat_ff       <= stat_in;
      ovf_ff        <= ovf_in;
      neg_ff        <= neg_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      num_ff        <= num_in;
      aux_ff        <= aux_in;
      den_ff        <= den_in;
      whole_ff      <= whole_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      big_ff        <= big_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      out_status_ff <= out_status_in;
      out_neg_ff    <= out_neg_in;
      out_whole_ff  <= out_whole_in;
      out_num_ff    <= out_num_in;
      out_den_ff    <= out_den_in;
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.negative  = out_neg_ff;
   assign rsp_ch.res_whole = out_whole_ff;
   assign rsp_ch.res_num   = out_num_ff;
   assign rsp_ch.res_den   = out_den_ff;

   // A zero denominator skips all arithmetic
   assert property (@(posedge clock) disable iff (reset)
      (accept && in_zero_den) |=> (state_ff == S_FINISH) && (stat_ff == ST_ZERO_DEN))
      else $error("zero denominator did not go straight to finish");

   // A good result is a proper fraction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_OK)) |-> (rsp_ch.res_num < rsp_ch.res_den))
      else $error("result numerator not below denominator");

   // Any error returns 0 + 0/1, not negative
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != ST_OK)) |->
         (rsp_ch.res_den == FRAC_BITS'(1)) && (rsp_ch.res_num == '0) &&
         (rsp_ch.res_whole == '0) && !rsp_ch.negative)
      else $error("error response carries a value");

   // The GCD loop never works with a zero second operand
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GCD_RUN) |-> (v_ff != '0))
      else $error("gcd operand went to zero");

endmodule

### test/mfa_checker.sv
`timescale 1ns / 100ps

module mfa_checker import mfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mfa_req_if.monitor  req_mon,
   mfa_rsp_if.monitor  rsp_mon,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      status_type            status;
      logic                  negative;
      logic [WHOLE_BITS-1:0] res_whole;
      logic [FRAC_BITS-1:0]  res_num;
      logic [FRAC_BITS-1:0]  res_den;
   } fraction_result_type;

   fraction_result_type expected_fractions[$];

   // Multiply in 128 bits or add in 65 bits and flag anything past 64 bits.
   function automatic logic [63:0] wide_mul(logic [63:0] a, logic [63:0] b, ref bit ovf);
      logic [127:0] p;
      p = a * b;
      if (p[127:64] != 0) ovf = 1;
      return p[63:0];
   endfunction

   function automatic logic [63:0] wide_add(logic [63:0] a, logic [63:0] b, ref bit ovf);
      logic [64:0] s;
      s = a + b;
      if (s[64]) ovf = 1;
      return s[63:0];
   endfunction

   function automatic fraction_result_type compute_fraction(func_type fn,
         logic [15:0] aw, logic [15:0] an, logic [15:0] ad,
         logic [15:0] bw, logic [15:0] bn, logic [15:0] bd);
      fraction_result_type r;
      bit ovf;
      bit neg;
      logic [63:0] a_imp, b_imp, p1, p2, num, den, g, x, y, t, whole;
      r = '{ST_OK, 1'b0, '0, '0, 32'd1};
      ovf = 0;
      neg = 0;
      if (ad == 0 || bd == 0) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      a_imp = wide_add(wide_mul(64'(aw), 64'(ad), ovf), 64'(an), ovf);
      b_imp = wide_add(wide_mul(64'(bw), 64'(bd), ovf), 64'(bn), ovf);
      case (fn)
         FN_ADD, FN_SUB: begin
            p1 = wide_mul(a_imp, 64'(bd), ovf);
            p2 = wide_mul(b_imp, 64'(ad), ovf);
            if (fn == FN_ADD) num = wide_add(p1, p2, ovf);
            else if (p1 >= p2) num = p1 - p2;
            else begin
               num = p2 - p1;
               neg = 1;
            end
            den = wide_mul(64'(ad), 64'(bd), ovf);
         end
         FN_MUL: begin
            num = wide_mul(a_imp, b_imp, ovf);
            den = wide_mul(64'(ad), 64'(bd), ovf);
         end
         default: begin
            if (b_imp == 0 && !ovf) begin
               r.status = ST_DIV_ZERO;
               return r;
            end
            num = wide_mul(a_imp, 64'(bd), ovf);
            den = wide_mul(64'(ad), b_imp, ovf);
         end
      endcase
      if (ovf || den == 0) begin
         r.status = ST_RANGE;
         return r;
      end
      x = num;
      y = den;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      g = x;
      num = num / g;
      den = den / g;
      whole = num / den;
      num = num % den;
      if (den > 64'hFFFF_FFFF || whole > 64'h7_FFFF_FFFF) begin
         r.status = ST_RANGE;
         return r;
      end
      if (whole == 0 && num == 0) neg = 0;
      r.negative = neg;
      r.res_whole = whole[WHOLE_BITS-1:0];
      r.res_num = num[FRAC_BITS-1:0];
      r.res_den = den[FRAC_BITS-1:0];
      return r;
   endfunction

   assign pending_count = expected_fractions.size();

   always @(posedge clock) begin
      fraction_result_type got, want;
      if (reset) begin
         fail_count <= 0;
         expected_fractions.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_fractions.push_back(compute_fraction(func_type'(req_mon.func),
               req_mon.a_whole, req_mon.a_num, req_mon.a_den,
               req_mon.b_whole, req_mon.b_num, req_mon.b_den));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status_type'(rsp_mon.status), rsp_mon.negative, rsp_mon.res_whole,
                    rsp_mon.res_num, rsp_mon.res_den};
            if (expected_fractions.size() == 0) begin
               $error("response transaction with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_fractions.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (got.status !== want.status)
                     $error("status: expected %0d, actual %0d", want.status, got.status);
                  if (got.negative !== want.negative)
                     $error("negative: expected %0d, actual %0d", want.negative,
                            got.negative);
                  if (got.res_whole !== want.res_whole)
                     $error("res_whole: expected %0d, actual %0d", want.res_whole,
                            got.res_whole);
                  if (got.res_num !== want.res_num)
                     $error("res_num: expected %0d, actual %0d", want.res_num,
                            got.res_num);
                  if (got.res_den !== want.res_den)
                     $error("res_den: expected %0d, actual %0d", want.res_den,
                            got.res_den);
               end
            end
         end
      end
   end

endmodule

### test/mixed_fraction_arith_unit_top_test.sv
`timescale 1ns / 100ps

module mixed_fraction_arith_unit_top_test;
   import mfa_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   long_stall;

   mfa_req_if req_ch ();
   mfa_rsp_if rsp_ch ();

   mixed_fraction_arith_unit_top #(.OPERAND_BITS(16)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   mfa_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.monitor),
      .rsp_mon       (rsp_ch.monitor),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Hard stop so that a hung run still ends.
   initial begin
      #(64'd12 * 64'd5_000_000);
      $display("Regression FAIL");
      $finish;
   end

   // Pick an operand field: mostly small, sometimes edge values or full range.
   function automatic logic [15:0] pick_field(bit allow_zero);
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0: v = 16'hFFFF;
         1: v = allow_zero ? 16'd0 : 16'd1;
         2, 3: v = 16'($urandom);
         default: v = 16'($urandom_range(allow_zero ? 0 : 1, 40));
      endcase
      return v;
   endfunction

   // Present one transaction at the falling edge and hold until accepted.
   task automatic send_fraction(func_type fn, logic [15:0] aw, logic [15:0] an,
                                logic [15:0] ad, logic [15:0] bw, logic [15:0] bn,
                                logic [15:0] bd);
      req_ch.valid   <= 1'b1;
      req_ch.func    <= fn;
      req_ch.a_whole <= aw;
      req_ch.a_num   <= an;
      req_ch.a_den   <= ad;
      req_ch.b_whole <= bw;
      req_ch.b_num   <= bn;
      req_ch.b_den   <= bd;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_ch.valid <= 1'b0;
   endtask

   // Receiver stall pattern, with one long hold-off while the sender keeps offering.
   initial begin
      int cycle_count;
      rsp_ch.ready = 1'b0;
      cycle_count = 0;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         cycle_count++;
         if (long_stall) rsp_ch.ready <= 1'b0;
         else if (cycle_count % 4000 < 1500) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         @(negedge clock);
      end
   end

   initial begin
      func_type fn;
      int gap;
      int burst;
      req_ch.valid   = 1'b0;
      req_ch.func    = FN_ADD;
      req_ch.a_whole = '0;
      req_ch.a_num   = '0;
      req_ch.a_den   = 16'd1;
      req_ch.b_whole = '0;
      req_ch.b_num   = '0;
      req_ch.b_den   = 16'd1;
      long_stall     = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: every operation, zero denominators, divide by zero, extremes.
      send_fraction(FN_ADD, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1, 16'd3);
      send_fraction(FN_SUB, 16'd1, 16'd1, 16'd2, 16'd2, 16'd1, 16'd3);
      send_fraction(FN_SUB, 16'd3, 16'd1, 16'd4, 16'd3, 16'd1, 16'd4);
      send_fraction(FN_SUB, 16'd2, 16'd0, 16'd5, 16'd1, 16'd1, 16'd7);
      send_fraction(FN_MUL, 16'd2, 16'd1, 16'd3, 16'd0, 16'd3, 16'd4);
      send_fraction(FN_DIV, 16'd5, 16'd0, 16'd1, 16'd0, 16'd2, 16'd3);
      send_fraction(FN_ADD, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
      send_fraction(FN_MUL, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
      send_fraction(FN_DIV, 16'd3, 16'd1, 16'd2, 16'd0, 16'd0, 16'd9);
      send_fraction(FN_DIV, 16'd0, 16'd0, 16'd7, 16'd0, 16'd0, 16'd9);
      send_fraction(FN_ADD, 16'd0, 16'd9, 16'd4, 16'd0, 16'd7, 16'd4);
      send_fraction(FN_MUL, 16'd0, 16'd0, 16'd3, 16'd5, 16'd2, 16'd3);
      send_fraction(FN_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fraction(FN_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
      send_fraction(FN_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_fraction(FN_DIV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
      send_fraction(FN_DIV, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      send_fraction(FN_ADD, 16'hAAAA, 16'h5555, 16'hAAAB, 16'h5555, 16'hAAAA, 16'h5557);
      send_fraction(FN_MUL, 16'h5555, 16'hAAAA, 16'h5557, 16'hAAAA, 16'h5555, 16'hAAAB);
      send_fraction(FN_ADD, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
      drop_valid();
      @(negedge clock);

      // Long receiver hold-off while requests keep coming, so the block backs up.
      long_stall = 1;
      fork
         begin
            repeat (3000) @(negedge clock);
            long_stall = 0;
         end
         begin
            repeat (6) send_fraction(FN_ADD, 16'd1, 16'd1, 16'd3, 16'd2, 16'd1, 16'd5);
            drop_valid();
         end
      join
      @(negedge clock);

      // Random bursts of transactions with random gaps between them.
      for (int sent = 0; sent < 1600; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            fn = func_type'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
               send_fraction(fn, pick_field(1), pick_field(1), pick_field(1),
                             pick_field(1), pick_field(1), pick_field(1));
            else
               send_fraction(fn, pick_field(1), pick_field(1), pick_field(0),
                             pick_field(1), pick_field(1), pick_field(0));
            sent++;
         end
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(negedge clock);
         end
      end
      drop_valid();

      while (pending_count != 0) @(negedge clock);
      repeat (700) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### mixed_fraction_arith_unit_top.f
design/mfa_pkg.sv
design/mfa_if.sv
design/mfa_alu.sv
design/mixed_fraction_arith_unit_top.sv
test/mfa_checker.sv
test/mixed_fraction_arith_unit_top_test.sv
